// ===== rtl/sha1mh_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1mh_pkg
// Shared constants, command/status types and round helpers for the SHA-1
// message hasher.
// ----------------------------------------------------------------------------
package sha1mh_pkg;

  // initial chaining values
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  // round constants, one per group of twenty rounds
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [5:0] FILL_LEN_POS = 6'd56;
  localparam logic [5:0] FILL_LAST    = 6'd63;
  localparam logic [6:0] LAST_ROUND   = 7'd79;

  // source of the byte shifted into the block line
  localparam logic [1:0] SEL_IN   = 2'd0;
  localparam logic [1:0] SEL_PAD  = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  // round groups
  localparam logic [1:0] GRP_CH  = 2'd0;
  localparam logic [1:0] GRP_PAR = 2'd1;
  localparam logic [1:0] GRP_MAJ = 2'd2;
  localparam logic [1:0] GRP_PR2 = 2'd3;

  typedef struct packed {
    logic       shift_en;   // shift one byte into the block line
    logic [1:0] byte_sel;   // which byte
    logic       count_en;   // add eight to the bit count
    logic       load_work;  // copy chain words into working vars
    logic       round_en;   // run one compression round
    logic [6:0] round_idx;  // round number, 0..79
    logic       chain_add;  // fold working vars into the chain
    logic       emit;       // load digest register, restart chain
  } cmd_t;

  typedef struct packed {
    logic fill_wrap;   // next byte completes the block
    logic fill_at_len; // block holds 56 bytes, length goes next
  } status_t;

  function automatic logic [1:0] round_group(input logic [6:0] idx);
    logic [1:0] g;
    if (idx < 7'd20)      g = GRP_CH;
    else if (idx < 7'd40) g = GRP_PAR;
    else if (idx < 7'd60) g = GRP_MAJ;
    else                  g = GRP_PR2;
    return g;
  endfunction

endpackage

// ===== rtl/sha1mh_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1mh_ctrl
// Sequencer: takes input items, drives padding, length append, the 80-round
// compression and the digest hand-off.
// ----------------------------------------------------------------------------
module sha1mh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                byte_valid,
  input  logic                msg_last,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  sha1mh_pkg::status_t stat,
  output sha1mh_pkg::cmd_t    cmd
);
  import sha1mh_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_ZERO = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_COMP = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ret_r, ret_nxt;
  logic [6:0] round_r, round_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    round_nxt     = round_r;
    cmd           = '0;
    cmd.round_idx = round_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (byte_valid) begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = SEL_IN;
            cmd.count_en = 1'b1;
          end
          if (byte_valid && stat.fill_wrap) begin
            cmd.load_work = 1'b1;
            state_nxt     = S_COMP;
            ret_nxt       = msg_last ? S_PAD : S_IDLE;
          end else if (msg_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = SEL_PAD;
        if (stat.fill_wrap) begin
          cmd.load_work = 1'b1;
          state_nxt     = S_COMP;
          ret_nxt       = S_ZERO;
        end else begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        if (stat.fill_at_len) begin
          state_nxt = S_LEN;
        end else begin
          cmd.shift_en = 1'b1;
          cmd.byte_sel = SEL_ZERO;
          if (stat.fill_wrap) begin
            cmd.load_work = 1'b1;
            state_nxt     = S_COMP;
            ret_nxt       = S_ZERO;
          end
        end
      end
      S_LEN: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = SEL_LEN;
        if (stat.fill_wrap) begin
          cmd.load_work = 1'b1;
          state_nxt     = S_COMP;
          ret_nxt       = S_OUT;
        end
      end
      S_COMP: begin
        cmd.round_en = 1'b1;
        if (round_r == LAST_ROUND) begin
          round_nxt = '0;
          state_nxt = S_ADD;
        end else begin
          round_nxt = round_r + 7'd1;
        end
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
        state_nxt     = ret_r;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.emit)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/sha1mh_dp.sv =====
// ----------------------------------------------------------------------------
// sha1mh_dp
// Datapath: 64-byte block shift line doubling as the message schedule,
// working variables, chaining words, bit count and digest register.
// ----------------------------------------------------------------------------
module sha1mh_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          data_byte,
  input  sha1mh_pkg::cmd_t    cmd,
  output sha1mh_pkg::status_t stat,
  output logic [159:0]        digest
);
  import sha1mh_pkg::*;

  logic [511:0]     blk_r, blk_nxt;
  logic [5:0]       fill_r, fill_nxt;
  logic [63:0]      bit_cnt_r, bit_cnt_nxt;
  logic [4:0][31:0] chain_r, chain_nxt;
  logic [4:0][31:0] work_r, work_nxt;
  logic [159:0]     digest_r, digest_nxt;

  logic [7:0]  shift_byte;
  logic [31:0] w_cur, w_mix, w_new;
  logic [31:0] fa, fb, fc, fd, fe;
  logic [31:0] f_val, k_val, t_val;

  assign stat.fill_wrap   = (fill_r == FILL_LAST);
  assign stat.fill_at_len = (fill_r == FILL_LEN_POS);
  assign digest           = digest_r;

  // byte source for the block line
  always_comb begin
    case (cmd.byte_sel)
      SEL_IN:   shift_byte = data_byte;
      SEL_PAD:  shift_byte = PAD_BYTE;
      SEL_ZERO: shift_byte = 8'h00;
      SEL_LEN:  shift_byte = bit_cnt_r[63:56];
      default:  shift_byte = 8'h00;
    endcase
  end

  // schedule taps: word k of the line sits at bits 511-32k
  assign w_cur = blk_r[511:480];
  assign w_mix = blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ blk_r[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};

  // round function
  assign fa = work_r[0];
  assign fb = work_r[1];
  assign fc = work_r[2];
  assign fd = work_r[3];
  assign fe = work_r[4];

  always_comb begin
    case (round_group(cmd.round_idx))
      GRP_CH: begin
        f_val = (fb & fc) | (~fb & fd);
        k_val = K0;
      end
      GRP_PAR: begin
        f_val = fb ^ fc ^ fd;
        k_val = K1;
      end
      GRP_MAJ: begin
        f_val = (fb & fc) | (fb & fd) | (fc & fd);
        k_val = K2;
      end
      GRP_PR2: begin
        f_val = fb ^ fc ^ fd;
        k_val = K3;
      end
      default: begin
        f_val = fb ^ fc ^ fd;
        k_val = K3;
      end
    endcase
  end

  assign t_val = {fa[26:0], fa[31:27]} + f_val + fe + k_val + w_cur;

  // register updates
  always_comb begin
    blk_nxt     = blk_r;
    fill_nxt    = fill_r;
    bit_cnt_nxt = bit_cnt_r;
    chain_nxt   = chain_r;
    work_nxt    = work_r;
    digest_nxt  = digest_r;

    if (cmd.shift_en) begin
      blk_nxt  = {blk_r[503:0], shift_byte};
      fill_nxt = fill_r + 6'd1;
    end else if (cmd.round_en) begin
      blk_nxt = {blk_r[479:0], w_new};
    end

    if (cmd.count_en) begin
      bit_cnt_nxt = bit_cnt_r + 64'd8;
    end else if (cmd.shift_en && (cmd.byte_sel == SEL_LEN)) begin
      bit_cnt_nxt = {bit_cnt_r[55:0], 8'h00};
    end

    if (cmd.load_work) begin
      work_nxt = chain_r;
    end else if (cmd.round_en) begin
      work_nxt[0] = t_val;
      work_nxt[1] = fa;
      work_nxt[2] = {fb[1:0], fb[31:2]};
      work_nxt[3] = fc;
      work_nxt[4] = fd;
    end

    if (cmd.chain_add) begin
      for (int i = 0; i < 5; i++) begin
        chain_nxt[i] = chain_r[i] + work_r[i];
      end
    end

    // digest hand-off and restart for the next message
    if (cmd.emit) begin
      digest_nxt  = {chain_r[4], chain_r[2], chain_r[3], chain_r[0], chain_r[1]};
      chain_nxt   = {IV4, IV3, IV2, IV1, IV0};
      bit_cnt_nxt = '0;
      fill_nxt    = '0;
    end
  end

  // control-side state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      bit_cnt_r <= '0;
      chain_r   <= {IV4, IV3, IV2, IV1, IV0};
    end else begin
      fill_r    <= fill_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      chain_r   <= chain_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    blk_r    <= blk_nxt;
    work_r   <= work_nxt;
    digest_r <= digest_nxt;
  end

endmodule

// ===== rtl/sha1_message_hasher.sv =====
// ----------------------------------------------------------------------------
// sha1_message_hasher
// Streaming SHA-1 digest of byte messages.
//
// Input channel: one item per message byte. in_tuser says whether in_tdata
// holds a message byte; in_tlast ends the message. A last item with no byte
// finishes the message as it stands (empty message allowed).
// Output channel: one 160-bit digest per message, after its last item.
//
// Flow: a byte is taken while the sequencer is idle; every 64th byte then
// holds the input off for the 80 rounds (one per cycle in the round unit)
// and the chain fold. A last item adds the pad, zero fill and length bytes
// (one byte per cycle through the block shift line outside compressions;
// the zero fill halts at the length position), one or two compressions,
// and the load of the digest register.
// The input stays ready only between messages and bytes; while a digest
// waits in the output register the next message is still taken, and the
// block stalls only when a new digest is due and the old one is not taken.
// Reset restores the initial chaining values and clears the bit count, the
// fill count and the output valid flag.
// ----------------------------------------------------------------------------
module sha1_message_hasher (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] byte_valid
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata   // [63:0] digest_high, [127:64] digest_mid,
                                   // [159:128] digest_low
);
  import sha1mh_pkg::*;

  cmd_t    cmd;
  status_t stat;

  sha1mh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .byte_valid (in_tuser),
    .msg_last   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha1mh_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_byte (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .digest    (out_tdata)
  );

  // a new digest never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("digest loaded while previous one pending");

  // output valid only rises after a digest load
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.emit))
    else $error("output valid without digest load");

  // last round is followed by the chain fold
  a_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.round_en && (cmd.round_idx == LAST_ROUND)) |=> cmd.chain_add)
    else $error("chain fold missing after last round");

  // no input taken during compression
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.round_en || cmd.chain_add) |-> !in_tready)
    else $error("input ready during compression");

endmodule
